### rtl/hpdmc_pkg.sv
// shared types, constants and functions of the hashed-path direct-mapped cache
package hpdmc_pkg;

    localparam int SLOTS_DEFAULT = 512;

    localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;

    localparam logic [23:0] MAX_SIZE_RESET = 24'd262144;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_STORE  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // slot reduction: steps per hash
    localparam int MOD_STEPS = 3;
    localparam int MOD_CW    = $clog2(MOD_STEPS);

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 160;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] hash;
        logic [31:0] handle;
        logic [23:0] size;
    } req_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
        logic [31:0] handle;
        logic [23:0] size;
    } entry_t;

    // first member sits in the top bits, so hit lands in bit 0
    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] store_total;
        logic [31:0] miss_total;
        logic [31:0] hit_total;
        logic        store_ok;
        logic [23:0] found_size;
        logic [31:0] found_handle;
        logic        hit;
    } result_t;

    typedef struct packed {
        logic busy;
    } back_status_t;

    typedef enum logic [2:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_MOD,
        BK_READ,
        BK_LOOKUP,
        BK_DONE
    } back_state_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        if (c == 8'h2F)
        begin
            r = 8'h5C;
        end
        return r;
    endfunction

endpackage

### rtl/hashed_path_direct_mapped_cache_unit.sv
// top level of the hashed-path direct-mapped cache
// Path bytes enter one per cycle: the front folds each byte into a running FNV-1a
// hash and never stalls on a non-final byte unless the two-entry request queue is
// full or a sweep is under way. The final byte of a path queues a request for the
// back end, which takes it through the slot reduction, the table read and the resolve
// step before the result register, one request at a time. When SLOTS is a power of
// two the slot is the low hash bits; otherwise the slot reduction runs a reciprocal
// multiply, a multiply-subtract and a final correction in turn. A clear adds a sweep
// over the single-port entry table; the same sweep runs after reset, and no byte is
// taken while a sweep is under way. Results wait in an output register so the front
// keeps taking bytes while one is pending.
module hashed_path_direct_mapped_cache_unit
#(
    parameter int SLOTS = hpdmc_pkg::SLOTS_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [23:0]                         cfg_wr_data,   // max_entry_size
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [hpdmc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // path_char, store_handle, store_size
    input  logic [1:0]                          s_axis_tuser,  // req_type
    input  logic                                s_axis_tlast,  // path_last
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // hit, found_handle, found_size, store_ok, hit_total, miss_total, store_total, zero pad
    output logic [hpdmc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    hpdmc_pkg::req_t         push_data;
    hpdmc_pkg::req_t         pop_data;
    hpdmc_pkg::back_status_t back_status;
    logic                    push;
    logic                    pop;
    logic                    full;
    logic                    empty;

    hpdmc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_req_type (s_axis_tuser),
        .in_char     (s_axis_tdata[7:0]),
        .in_last     (s_axis_tlast),
        .in_handle   (s_axis_tdata[39:8]),
        .in_size     (s_axis_tdata[63:40]),
        .back_status (back_status),
        .q_full      (full),
        .q_push      (push),
        .q_data      (push_data)
    );

    hpdmc_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    hpdmc_back
    #(
        .SLOTS (SLOTS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (empty),
        .q_data      (pop_data),
        .q_pop       (pop),
        .status      (back_status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata)
    );

endmodule

### rtl/hpdmc_front.sv
// front end: takes path bytes, keeps the running hash, queues finished requests
module hpdmc_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     in_req_type,
    input  logic [7:0]                     in_char,
    input  logic                           in_last,
    input  logic [31:0]                    in_handle,
    input  logic [23:0]                    in_size,
    input  hpdmc_pkg::back_status_t        back_status,
    input  logic                           q_full,
    output logic                           q_push,
    output hpdmc_pkg::req_t                q_data
);

    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [31:0] hash_upd;
    logic        accept;

    assign in_ready = !q_full && !back_status.busy;
    assign accept   = in_valid && in_ready;

    // one xor and one constant multiply per byte; a zero byte leaves the hash unchanged
    always_comb
    begin
        hash_upd = (hash_reg ^ {24'd0, hpdmc_pkg::fold_char(in_char)})
                   * hpdmc_pkg::FNV_PRIME;
        hash_next = (in_char != 8'd0) ? hash_upd : hash_reg;
    end

    assign q_push          = accept && in_last;
    assign q_data.req_type = in_req_type;
    assign q_data.hash     = hash_next;
    assign q_data.handle   = in_handle;
    assign q_data.size     = in_size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= hpdmc_pkg::FNV_BASIS;
        end
        else if (accept)
        begin
            hash_reg <= in_last ? hpdmc_pkg::FNV_BASIS : hash_next;
        end
    end

endmodule

### rtl/hpdmc_fifo.sv
// two-entry request queue between front and back
module hpdmc_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hpdmc_pkg::req_t push_data,
    output logic            full,
    input  logic            pop,
    output hpdmc_pkg::req_t pop_data,
    output logic            empty
);

    hpdmc_pkg::req_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/hpdmc_back.sv
// back end: slot reduction, table access, counters and result register
module hpdmc_back
#(
    parameter int SLOTS = hpdmc_pkg::SLOTS_DEFAULT
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [23:0]                           cfg_wr_data,
    input  logic                                  q_empty,
    input  hpdmc_pkg::req_t                       q_data,
    output logic                                  q_pop,
    output hpdmc_pkg::back_status_t               status,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [hpdmc_pkg::OUT_DATA_W-1:0]      out_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int RW = IW + 1;
    localparam logic [RW-1:0] SLOTS_RW = RW'(SLOTS);
    localparam logic [31:0] SLOTS_32 = 32'(SLOTS);
    localparam logic [32:0] RECIP = 33'((66'd1 << (32 + IW)) / SLOTS);
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
    localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    hpdmc_pkg::back_state_t state_reg;
    hpdmc_pkg::back_state_t state_next;

    hpdmc_pkg::req_t  req_reg;
    logic [IW-1:0]    rem_reg;
    logic [IW-1:0]    rem_next;
    logic [31:0]      quot_reg;
    logic [31:0]      quot_next;
    logic [RW-1:0]    rem_wide_reg;
    logic [RW-1:0]    rem_wide_next;
    logic [64:0]      recip_prod;
    logic [31:0]      recip_diff;
    logic [hpdmc_pkg::MOD_CW-1:0] step_reg;
    logic [IW-1:0]    sweep_reg;
    logic [23:0]      max_size_reg;

    logic [31:0]      hit_cnt_reg;
    logic [31:0]      miss_cnt_reg;
    logic [31:0]      store_cnt_reg;
    logic [31:0]      hit_cnt_next;
    logic [31:0]      miss_cnt_next;
    logic [31:0]      store_cnt_next;

    hpdmc_pkg::entry_t mem [SLOTS];
    hpdmc_pkg::entry_t rd_data_reg;

    hpdmc_pkg::result_t res_reg;
    hpdmc_pkg::result_t res_next;
    hpdmc_pkg::result_t out_data_reg;
    logic               out_valid_reg;

    logic               mem_rd_en;
    logic               mem_wr_en;
    logic [IW-1:0]      mem_wr_addr;
    hpdmc_pkg::entry_t  mem_wr_data;
    logic               out_load;
    logic               lookup_hit;
    logic               store_ok;
    logic               is_clear;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign is_clear  = (req_reg.req_type == hpdmc_pkg::REQ_CLEAR);

    // remainder by the slot count: reciprocal multiply, multiply-subtract, correction
    always_comb
    begin
        recip_prod    = {33'd0, req_reg.hash} * {32'd0, RECIP};
        quot_next     = 32'(recip_prod >> (32 + IW));
        recip_diff    = req_reg.hash - quot_reg * SLOTS_32;
        rem_wide_next = recip_diff[RW-1:0];
        rem_next      = (rem_wide_reg >= SLOTS_RW) ? IW'(rem_wide_reg - SLOTS_RW)
                                                   : rem_wide_reg[IW-1:0];
    end

    // request resolution
    always_comb
    begin
        lookup_hit = rd_data_reg.valid && (rd_data_reg.tag == req_reg.hash) &&
                     (rd_data_reg.handle != 32'd0) && (rd_data_reg.size != 24'd0);
        store_ok   = (req_reg.handle != 32'd0) && (req_reg.size != 24'd0) &&
                     (req_reg.size <= max_size_reg);
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        store_cnt_next = store_cnt_reg;
        res_next       = '0;
        case (req_reg.req_type)
            hpdmc_pkg::REQ_LOOKUP:
            begin
                if (lookup_hit)
                begin
                    res_next.hit          = 1'b1;
                    res_next.found_handle = rd_data_reg.handle;
                    res_next.found_size   = rd_data_reg.size;
                    hit_cnt_next          = hit_cnt_reg + 32'd1;
                end
                else
                begin
                    miss_cnt_next = miss_cnt_reg + 32'd1;
                end
            end
            hpdmc_pkg::REQ_STORE:
            begin
                if (store_ok)
                begin
                    res_next.store_ok = 1'b1;
                    store_cnt_next    = store_cnt_reg + 32'd1;
                end
            end
            hpdmc_pkg::REQ_CLEAR:
            begin
                hit_cnt_next   = '0;
                miss_cnt_next  = '0;
                store_cnt_next = '0;
            end
            default:
            begin
                hit_cnt_next = hit_cnt_reg;
            end
        endcase
        res_next.hit_total   = hit_cnt_next;
        res_next.miss_total  = miss_cnt_next;
        res_next.store_total = store_cnt_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hpdmc_pkg::BK_SWEEP:
            begin
                if (sweep_reg == LAST_SLOT)
                begin
                    state_next = hpdmc_pkg::BK_IDLE;
                end
            end
            hpdmc_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = SLOTS_POW2 ? hpdmc_pkg::BK_READ : hpdmc_pkg::BK_MOD;
                end
            end
            hpdmc_pkg::BK_MOD:
            begin
                if (step_reg == hpdmc_pkg::MOD_CW'(hpdmc_pkg::MOD_STEPS - 1))
                begin
                    state_next = hpdmc_pkg::BK_READ;
                end
            end
            hpdmc_pkg::BK_READ:
            begin
                state_next = hpdmc_pkg::BK_LOOKUP;
            end
            hpdmc_pkg::BK_LOOKUP:
            begin
                state_next = hpdmc_pkg::BK_DONE;
            end
            hpdmc_pkg::BK_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = is_clear ? hpdmc_pkg::BK_SWEEP : hpdmc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = hpdmc_pkg::BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop       = 1'b0;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = rem_reg;
        mem_wr_data = '0;
        out_load    = 1'b0;
        status.busy = 1'b0;
        unique case (state_reg)
            hpdmc_pkg::BK_SWEEP:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = sweep_reg;
                status.busy = 1'b1;
            end
            hpdmc_pkg::BK_IDLE:
            begin
                q_pop = !q_empty;
            end
            hpdmc_pkg::BK_MOD:
            begin
                q_pop = 1'b0;
            end
            hpdmc_pkg::BK_READ:
            begin
                mem_rd_en = 1'b1;
            end
            hpdmc_pkg::BK_LOOKUP:
            begin
                mem_wr_en          = (req_reg.req_type == hpdmc_pkg::REQ_STORE) && store_ok;
                mem_wr_data.valid  = 1'b1;
                mem_wr_data.tag    = req_reg.hash;
                mem_wr_data.handle = req_reg.handle;
                mem_wr_data.size   = req_reg.size;
            end
            hpdmc_pkg::BK_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // entry table
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[rem_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            req_reg <= q_data;
            rem_reg <= SLOTS_POW2 ? q_data.hash[IW-1:0] : '0;
        end
        else if (state_reg == hpdmc_pkg::BK_MOD)
        begin
            quot_reg     <= quot_next;
            rem_wide_reg <= rem_wide_next;
            rem_reg      <= rem_next;
        end
        if (state_reg == hpdmc_pkg::BK_LOOKUP)
        begin
            res_reg <= res_next;
        end
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpdmc_pkg::BK_SWEEP;
            sweep_reg     <= '0;
            step_reg      <= '0;
            max_size_reg  <= hpdmc_pkg::MAX_SIZE_RESET;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            store_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                max_size_reg <= cfg_wr_data;
            end
            if (state_reg == hpdmc_pkg::BK_SWEEP)
            begin
                sweep_reg <= (sweep_reg == LAST_SLOT) ? '0 : sweep_reg + IW'(1);
            end
            if (q_pop)
            begin
                step_reg <= '0;
            end
            else if (state_reg == hpdmc_pkg::BK_MOD)
            begin
                step_reg <= step_reg + hpdmc_pkg::MOD_CW'(1);
            end
            if (state_reg == hpdmc_pkg::BK_LOOKUP)
            begin
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                store_cnt_reg <= store_cnt_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("request taken from an empty queue");

    a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_rd_en && mem_wr_en))
        else $error("table read and write in the same cycle");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hpdmc_pkg::BK_READ) |-> ({1'b0, rem_reg} < SLOTS_RW))
        else $error("slot index out of range");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hpdmc_pkg::BK_LOOKUP && is_clear) |=>
        (hit_cnt_reg == 32'd0 && miss_cnt_reg == 32'd0 && store_cnt_reg == 32'd0))
        else $error("counters not cleared");

    a_hit_store_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hpdmc_pkg::BK_DONE) |-> !(res_reg.hit && res_reg.store_ok))
        else $error("result flags hit and store both set");

endmodule

### verif/hashed_path_direct_mapped_cache_unit_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the hashed-path direct-mapped cache top level
module hashed_path_direct_mapped_cache_unit_test;

    localparam int SLOT_COUNT = hpdmc_pkg::SLOTS_DEFAULT;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 600;
    localparam int PHASE_ITEMS = 330;
    localparam int POOL_PATHS = 40;

    typedef logic [7:0] char_list_t [$];

    typedef struct {
        logic [1:0]  req;
        logic [7:0]  ch;
        logic        last;
        logic [31:0] handle;
        logic [23:0] size;
        logic        hold_for_replies;
    } path_byte_t;

    typedef struct {
        logic        hit;
        logic [31:0] handle;
        logic [23:0] size;
        logic        ok;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] stores;
    } cache_reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [23:0]           cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [hpdmc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;   // path_char, store_handle, store_size
    logic [1:0]            s_axis_tuser = '0;   // req_type
    logic                  s_axis_tlast = 1'b0; // path_last
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // hit, found_handle, found_size, store_ok, hit_total, miss_total, store_total, zero pad
    logic [hpdmc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // cache image kept alongside the block
    logic [31:0] trail_hash = hpdmc_pkg::FNV_BASIS;
    logic        slot_live [SLOT_COUNT];
    logic [31:0] slot_tag [SLOT_COUNT];
    logic [31:0] slot_handle [SLOT_COUNT];
    logic [23:0] slot_size [SLOT_COUNT];
    logic [31:0] lookup_hits = '0;
    logic [31:0] lookup_misses = '0;
    logic [31:0] stores_taken = '0;
    logic [23:0] size_limit = hpdmc_pkg::MAX_SIZE_RESET;

    path_byte_t   byte_queue [$];
    path_byte_t   next_byte;
    cache_reply_t replies_due [$];
    char_list_t   path_pool [POOL_PATHS];

    int send_gap_pct = 27;
    int recv_stall_pct = 55;
    int items_queued = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    hashed_path_direct_mapped_cache_unit
    #(
        .SLOTS(SLOT_COUNT)
    )
    i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] canon_char(input logic [7:0] c);
        if (c == CH_SLASH)
        begin
            return CH_BACKSLASH;
        end
        if (c >= "A" && c <= "Z")
        begin
            return c | 8'h20;
        end
        return c;
    endfunction

    function automatic char_list_t as_chars(input string s);
        char_list_t q;
        for (int i = 0; i < s.len(); i++)
        begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    task automatic absorb_path_byte(input logic [1:0] req, input logic [7:0] ch,
                                    input logic last, input logic [31:0] handle,
                                    input logic [23:0] size);
        logic [31:0]  h;
        int unsigned  s;
        cache_reply_t r;
        if (ch != 8'h00)
        begin
            trail_hash = (trail_hash ^ {24'h0, canon_char(ch)}) * hpdmc_pkg::FNV_PRIME;
        end
        if (last)
        begin
            h = trail_hash;
            trail_hash = hpdmc_pkg::FNV_BASIS;
            s = h % SLOT_COUNT;
            r = '{default: '0};
            case (req)
                hpdmc_pkg::REQ_LOOKUP:
                begin
                    if (slot_live[s] && slot_tag[s] == h && slot_handle[s] != 0 &&
                        slot_size[s] != 0)
                    begin
                        r.hit = 1'b1;
                        r.handle = slot_handle[s];
                        r.size = slot_size[s];
                        lookup_hits++;
                    end
                    else
                    begin
                        lookup_misses++;
                    end
                end
                hpdmc_pkg::REQ_STORE:
                begin
                    if (handle != 0 && size != 0 && size <= size_limit)
                    begin
                        slot_live[s] = 1'b1;
                        slot_tag[s] = h;
                        slot_handle[s] = handle;
                        slot_size[s] = size;
                        stores_taken++;
                        r.ok = 1'b1;
                    end
                end
                hpdmc_pkg::REQ_CLEAR:
                begin
                    foreach (slot_live[i])
                    begin
                        slot_live[i] = 1'b0;
                    end
                    lookup_hits = '0;
                    lookup_misses = '0;
                    stores_taken = '0;
                end
                default:
                begin
                end
            endcase
            r.hits = lookup_hits;
            r.misses = lookup_misses;
            r.stores = stores_taken;
            replies_due.push_back(r);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    task automatic check_reply(input hpdmc_pkg::result_t got);
        cache_reply_t want;
        if (replies_due.size() == 0)
        begin
            mismatches++;
            $display("%0t: reply with none expected, actual %h", $time, got);
            return;
        end
        want = replies_due.pop_front();
        compare_field("hit", 32'(want.hit), 32'(got.hit));
        compare_field("found_handle", want.handle, got.found_handle);
        compare_field("found_size", 32'(want.size), 32'(got.found_size));
        compare_field("store_ok", 32'(want.ok), 32'(got.store_ok));
        compare_field("hit_total", want.hits, got.hit_total);
        compare_field("miss_total", want.misses, got.miss_total);
        compare_field("store_total", want.stores, got.store_total);
    endtask

    task automatic queue_path(input char_list_t text, input logic [1:0] req,
                              input logic [31:0] handle, input logic [23:0] size,
                              input logic hold);
        path_byte_t b;
        foreach (text[i])
        begin
            b.ch = text[i];
            b.last = (i == text.size() - 1);
            b.hold_for_replies = hold && (i == 0);
            if (b.last)
            begin
                b.req = req;
                b.handle = handle;
                b.size = size;
            end
            else
            begin
                // ignored fields on inner bytes carry noise
                b.req = 2'($urandom_range(3));
                b.handle = $urandom;
                b.size = 24'($urandom);
            end
            byte_queue.push_back(b);
            items_queued++;
        end
    endtask

    task automatic queue_random_request();
        char_list_t  text;
        logic [1:0]  req;
        logic [31:0] handle;
        logic [23:0] size;
        int          r;
        if ($urandom_range(9) < 7)
        begin
            text = path_pool[$urandom_range(POOL_PATHS - 1)];
            // same path spelt differently
            foreach (text[i])
            begin
                if (((text[i] >= "a" && text[i] <= "z") || (text[i] >= "A" && text[i] <= "Z"))
                    && $urandom_range(1))
                begin
                    text[i] = text[i] ^ 8'h20;
                end
                else if ((text[i] == CH_SLASH || text[i] == CH_BACKSLASH) && $urandom_range(1))
                begin
                    text[i] = (text[i] == CH_SLASH) ? CH_BACKSLASH : CH_SLASH;
                end
            end
        end
        else
        begin
            repeat ($urandom_range(1, 8))
            begin
                text.push_back(8'($urandom_range(255)));
            end
        end
        r = $urandom_range(99);
        if (r < 45)
        begin
            req = hpdmc_pkg::REQ_LOOKUP;
        end
        else if (r < 85)
        begin
            req = hpdmc_pkg::REQ_STORE;
        end
        else if (r < 88)
        begin
            req = hpdmc_pkg::REQ_CLEAR;
        end
        else if (r < 91)
        begin
            req = REQ_UNUSED;
        end
        else
        begin
            req = hpdmc_pkg::REQ_LOOKUP;
        end
        handle = ($urandom_range(19) == 0) ? 32'h0 : $urandom;
        case ($urandom_range(5))
            0, 1: size = 24'($urandom_range(1, 64));
            2: size = 24'($urandom);
            3: size = size_limit;
            4: size = size_limit + 24'd1;
            default: size = 24'($urandom_range(1, size_limit));
        endcase
        if ($urandom_range(19) == 0)
        begin
            size = '0;
        end
        queue_path(text, req, handle, size, $urandom_range(49) == 0);
    endtask

    task automatic settle();
        while (byte_queue.size() != 0 || s_axis_tvalid || replies_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input logic [23:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        size_limit = v;
    endtask

    task automatic run_random_phase(input logic [23:0] limit, input int gap, input int stall);
        int start;
        settle();
        set_limit(limit);
        send_gap_pct = gap;
        recv_stall_pct = stall;
        start = items_queued;
        while (items_queued - start < PHASE_ITEMS)
        begin
            queue_random_request();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            s_axis_tlast <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_path_byte(s_axis_tuser, s_axis_tdata[7:0], s_axis_tlast,
                                 s_axis_tdata[39:8], s_axis_tdata[63:40]);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (byte_queue.size() != 0 &&
                    !(byte_queue[0].hold_for_replies && replies_due.size() != 0) &&
                    $urandom_range(99) >= send_gap_pct)
                begin
                    next_byte = byte_queue.pop_front();
                    s_axis_tdata <= {next_byte.size, next_byte.handle, next_byte.ch};
                    s_axis_tuser <= next_byte.req;
                    s_axis_tlast <= next_byte.last;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_reply(m_axis_tdata);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("hashed_path_direct_mapped_cache_unit_test NOT OK");
        $finish;
    end

    initial
    begin
        char_list_t text;
        string      charset;
        charset = "aBcDeFgHz/\\._-09QxY";
        foreach (slot_live[i])
        begin
            slot_live[i] = 1'b0;
        end
        foreach (path_pool[k])
        begin
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(9) == 0)
                begin
                    path_pool[k].push_back(8'($urandom_range(255)));
                end
                else
                begin
                    path_pool[k].push_back(charset[$urandom_range(charset.len() - 1)]);
                end
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        // directed: folding, zero bytes, rejected stores, unused code, clear
        queue_path(as_chars("A/b"), hpdmc_pkg::REQ_LOOKUP, 32'h0, 24'h0, 1'b0);
        queue_path(as_chars("a\\B"), hpdmc_pkg::REQ_STORE, 32'hFFFFFFFF,
                   hpdmc_pkg::MAX_SIZE_RESET, 1'b0);
        text = as_chars("A");
        text.push_back(8'h00);
        text.push_back(CH_SLASH);
        text.push_back("b");
        queue_path(text, hpdmc_pkg::REQ_LOOKUP, 32'h0, 24'h0, 1'b0);
        queue_path(as_chars("z"), hpdmc_pkg::REQ_STORE, 32'h0, 24'd5, 1'b0);
        queue_path(as_chars("z"), hpdmc_pkg::REQ_STORE, 32'h1, 24'd0, 1'b0);
        queue_path(as_chars("z"), hpdmc_pkg::REQ_STORE, 32'h1,
                   hpdmc_pkg::MAX_SIZE_RESET + 24'd1, 1'b0);
        text = {8'hFF};
        queue_path(text, hpdmc_pkg::REQ_STORE, 32'h80000001, 24'h000100, 1'b0);
        queue_path(text, hpdmc_pkg::REQ_LOOKUP, 32'h0, 24'h0, 1'b1);
        text = {8'h00};
        queue_path(text, REQ_UNUSED, 32'hFFFFFFFF, 24'hFFFFFF, 1'b0);
        queue_path(as_chars("@[Z"), hpdmc_pkg::REQ_LOOKUP, 32'h0, 24'h0, 1'b0);
        queue_path(text, hpdmc_pkg::REQ_CLEAR, 32'h0, 24'h0, 1'b0);
        queue_path(as_chars("a/B"), hpdmc_pkg::REQ_LOOKUP, 32'h0, 24'h0, 1'b0);

        // size limit extremes
        settle();
        set_limit(24'h0);
        queue_path(as_chars("q"), hpdmc_pkg::REQ_STORE, 32'h7, 24'd1, 1'b0);
        settle();
        set_limit(24'hFFFFFF);
        queue_path(as_chars("q"), hpdmc_pkg::REQ_STORE, 32'h7, 24'hFFFFFF, 1'b0);
        queue_path(as_chars("Q"), hpdmc_pkg::REQ_LOOKUP, 32'h0, 24'h0, 1'b0);
        settle();
        set_limit(24'd1);
        queue_path(as_chars("r"), hpdmc_pkg::REQ_STORE, 32'h9, 24'd1, 1'b0);
        queue_path(as_chars("s"), hpdmc_pkg::REQ_STORE, 32'h9, 24'd2, 1'b0);
        queue_path(as_chars("R"), hpdmc_pkg::REQ_LOOKUP, 32'h0, 24'h0, 1'b0);

        run_random_phase(hpdmc_pkg::MAX_SIZE_RESET, 27, 55);
        run_random_phase(24'hFFFFFF, 55, 27);
        run_random_phase(24'($urandom_range(1, 65535)), 0, 0);

        settle();
        if (mismatches == 0)
        begin
            $display("hashed_path_direct_mapped_cache_unit_test OK");
        end
        else
        begin
            $display("hashed_path_direct_mapped_cache_unit_test NOT OK");
        end
        $finish;
    end

endmodule

### files.f
rtl/hpdmc_pkg.sv
rtl/hpdmc_front.sv
rtl/hpdmc_fifo.sv
rtl/hpdmc_back.sv
rtl/hashed_path_direct_mapped_cache_unit.sv
verif/hashed_path_direct_mapped_cache_unit_test.sv
